// ===== src/pblm_pkg.sv =====
// Shared constants, types and codes for the partition block-to-LBA mapper.
package pblm_pkg;

  // Table geometry and unit sizes.
  localparam int NUM_LOGICAL         = 64;
  localparam int BLOCK_BYTES         = 1024;
  localparam int SECTOR_BYTES        = 512;
  localparam int FIRST_LOGICAL_MINOR = 16;

  localparam int NSLOTS       = NUM_LOGICAL + 1;
  localparam int SLOT_W       = $clog2(NSLOTS);
  localparam int CNT_W        = $clog2(NSLOTS + 1);
  localparam int SECTOR_SHIFT = $clog2(SECTOR_BYTES);
  localparam int BLOCK_SHIFT  = $clog2(BLOCK_BYTES);

  // Field widths.
  localparam int FUNC_W   = 1;
  localparam int IDX_W    = 7;
  localparam int DATA_W   = 32;
  localparam int BLOCK_W  = 31;
  localparam int BYTES_W  = 20;
  localparam int DEV_W    = 7;
  localparam int OFF_W    = 41;
  localparam int LBA_W    = 28;
  localparam int SCNT_W   = 8;

  // Datapath widths for the region walk.
  localparam int SPAN_W = DATA_W + SECTOR_SHIFT;
  localparam int POS_W  = BLOCK_W + $clog2(BLOCK_BYTES + 1);
  localparam int END_W  = ((SPAN_W + SLOT_W + 1) > POS_W) ? (SPAN_W + SLOT_W + 1) : POS_W;

  // Function and status codes.
  localparam logic FUNC_TABLE_WRITE = 1'b0;
  localparam logic FUNC_LOOKUP      = 1'b1;
  localparam logic STATUS_OK        = 1'b0;
  localparam logic STATUS_NOT_FOUND = 1'b1;

  // Device number reported for the primary slot.
  localparam int PRIMARY_DEVICE = 1;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WALK,
    ST_OFFSET,
    ST_LBA,
    ST_RESULT
  } state_t;

  // Write request into the slot table.
  typedef struct packed {
    logic              en;
    logic [SLOT_W-1:0] addr;
    logic [DATA_W-1:0] base;
    logic [DATA_W-1:0] size;
  } slot_wr_t;

  // One slot as read back from the table.
  typedef struct packed {
    logic [DATA_W-1:0] base;
    logic [DATA_W-1:0] size;
  } slot_data_t;

endpackage

// ===== src/pblm_slot_table.sv =====
// Partition slot table: base and size memories with per-entry valid bits.
module pblm_slot_table (
  input  logic                       clk,
  input  logic                       rst_n,
  input  pblm_pkg::slot_wr_t         wr,
  input  logic                       rd_en,
  input  logic [pblm_pkg::SLOT_W-1:0] rd_addr,
  output pblm_pkg::slot_data_t       rd_data
);

  logic [pblm_pkg::DATA_W-1:0] base_mem [pblm_pkg::NSLOTS];
  logic [pblm_pkg::DATA_W-1:0] size_mem [pblm_pkg::NSLOTS];
  logic [pblm_pkg::NSLOTS-1:0] vld_r;
  logic [pblm_pkg::DATA_W-1:0] base_q_r;
  logic [pblm_pkg::DATA_W-1:0] size_q_r;
  logic                        vld_q_r;

  // Memory write port.
  always_ff @(posedge clk) begin
    if (wr.en) begin
      base_mem[wr.addr] <= wr.base;
      size_mem[wr.addr] <= wr.size;
    end
  end

  // Valid bits: an entry never written reads as zero.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (wr.en) begin
      vld_r[wr.addr] <= 1'b1;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      base_q_r <= base_mem[rd_addr];
      size_q_r <= size_mem[rd_addr];
      vld_q_r  <= vld_r[rd_addr];
    end
  end

  assign rd_data.base = vld_q_r ? base_q_r : '0;
  assign rd_data.size = vld_q_r ? size_q_r : '0;

endmodule

// ===== src/partition_block_to_lba_mapper.sv =====
// Partition block-to-LBA mapper top level: sequencer, region walk and result register.
// A table write goes from idle straight to the result state with an all-zero result.
// A lookup reads one table slot per cycle through a single adder and compare; a match
// on slot k goes through the offset and LBA states, a miss straight to the result state.
// The input stalls until the result is loaded into the output register.
// Synchronous active-low reset clears the sequencer, the output valid and all slot valid bits.
module partition_block_to_lba_mapper (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [pblm_pkg::FUNC_W-1:0]   in_func,
  input  logic [pblm_pkg::IDX_W-1:0]    in_slot_index,
  input  logic [pblm_pkg::DATA_W-1:0]   in_slot_base,
  input  logic [pblm_pkg::DATA_W-1:0]   in_slot_size,
  input  logic [pblm_pkg::BLOCK_W-1:0]  in_block_number,
  input  logic [pblm_pkg::BYTES_W-1:0]  in_byte_count,
  input  logic                          in_is_write,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_status,
  output logic [pblm_pkg::DEV_W-1:0]    out_device_number,
  output logic [pblm_pkg::OFF_W-1:0]    out_offset_bytes,
  output logic [pblm_pkg::LBA_W-1:0]    out_lba,
  output logic [pblm_pkg::SCNT_W-1:0]   out_sector_count,
  output logic                          out_command_is_write
);

  pblm_pkg::state_t state_r, state_nxt;

  // Walk control.
  logic [pblm_pkg::CNT_W-1:0]  rd_cnt_r, rd_cnt_nxt;
  logic                        dv_r, dv_nxt;
  logic [pblm_pkg::SLOT_W-1:0] dq_r, dq_nxt;
  logic                        rd_en;

  // Lookup operands and running region end.
  logic [pblm_pkg::POS_W-1:0]  pos_r, pos_nxt;
  logic [pblm_pkg::END_W-1:0]  end_r, end_nxt;
  logic [pblm_pkg::SLOT_W-1:0] hit_slot_r, hit_slot_nxt;
  logic [pblm_pkg::DATA_W-1:0] hit_base_r, hit_base_nxt;
  logic [pblm_pkg::SCNT_W-1:0] scnt_r, scnt_nxt;
  logic                        cmd_wr_r, cmd_wr_nxt;

  // Pending result.
  logic                        res_status_r, res_status_nxt;
  logic [pblm_pkg::DEV_W-1:0]  res_dev_r, res_dev_nxt;
  logic [pblm_pkg::OFF_W-1:0]  res_off_r, res_off_nxt;
  logic [pblm_pkg::LBA_W-1:0]  res_lba_r, res_lba_nxt;
  logic [pblm_pkg::SCNT_W-1:0] res_scnt_r, res_scnt_nxt;
  logic                        res_cmd_r, res_cmd_nxt;

  // Output register.
  logic                        out_valid_r, out_valid_nxt;
  logic                        out_load;
  logic                        out_status_r;
  logic [pblm_pkg::DEV_W-1:0]  out_dev_r;
  logic [pblm_pkg::OFF_W-1:0]  out_off_r;
  logic [pblm_pkg::LBA_W-1:0]  out_lba_r;
  logic [pblm_pkg::SCNT_W-1:0] out_scnt_r;
  logic                        out_cmd_r;

  pblm_pkg::slot_wr_t   tbl_wr;
  pblm_pkg::slot_data_t tbl_rd;

  logic in_accept;

  assign in_stall  = (state_r != pblm_pkg::ST_IDLE);
  assign in_accept = in_valid && !in_stall;

  // Table writes with an in-range slot index go straight to the memories when accepted.
  assign tbl_wr.en   = in_accept && (in_func == pblm_pkg::FUNC_TABLE_WRITE) &&
                       (int'(in_slot_index) < pblm_pkg::NSLOTS);
  assign tbl_wr.addr = in_slot_index[pblm_pkg::SLOT_W-1:0];
  assign tbl_wr.base = in_slot_base;
  assign tbl_wr.size = in_slot_size;

  pblm_slot_table u_table (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr      (tbl_wr),
    .rd_en   (rd_en),
    .rd_addr (rd_cnt_r[pblm_pkg::SLOT_W-1:0]),
    .rd_data (tbl_rd)
  );

  // Sequencer: next state and datapath updates.
  always_comb begin
    logic [pblm_pkg::SPAN_W-1:0]  span;
    logic [pblm_pkg::END_W-1:0]   new_end;
    logic [pblm_pkg::END_W-1:0]   diff;
    logic [pblm_pkg::BYTES_W:0]   bytes_up;
    logic [pblm_pkg::DATA_W-1:0]  off_sectors;
    logic [pblm_pkg::DATA_W-1:0]  lba_sum;
    int                           dev_full;

    state_nxt      = state_r;
    rd_cnt_nxt     = rd_cnt_r;
    dv_nxt         = 1'b0;
    dq_nxt         = dq_r;
    rd_en          = 1'b0;
    pos_nxt        = pos_r;
    end_nxt        = end_r;
    hit_slot_nxt   = hit_slot_r;
    hit_base_nxt   = hit_base_r;
    scnt_nxt       = scnt_r;
    cmd_wr_nxt     = cmd_wr_r;
    res_status_nxt = res_status_r;
    res_dev_nxt    = res_dev_r;
    res_off_nxt    = res_off_r;
    res_lba_nxt    = res_lba_r;
    res_scnt_nxt   = res_scnt_r;
    res_cmd_nxt    = res_cmd_r;
    out_load       = 1'b0;

    span        = {tbl_rd.size, {pblm_pkg::SECTOR_SHIFT{1'b0}}};
    new_end     = end_r + pblm_pkg::END_W'(span);
    diff        = pblm_pkg::END_W'(pos_r) - end_r;
    bytes_up    = {1'b0, in_byte_count} + (pblm_pkg::BYTES_W+1)'(pblm_pkg::SECTOR_BYTES - 1);
    off_sectors = pblm_pkg::DATA_W'(res_off_r >> pblm_pkg::SECTOR_SHIFT);
    lba_sum     = hit_base_r + off_sectors;
    dev_full    = int'(hit_slot_r) + pblm_pkg::FIRST_LOGICAL_MINOR - 1;

    case (state_r)
      pblm_pkg::ST_IDLE: begin
        if (in_accept) begin
          if (in_func == pblm_pkg::FUNC_TABLE_WRITE) begin
            // Table write: the result is all zero.
            res_status_nxt = pblm_pkg::STATUS_OK;
            res_dev_nxt    = '0;
            res_off_nxt    = '0;
            res_lba_nxt    = '0;
            res_scnt_nxt   = '0;
            res_cmd_nxt    = 1'b0;
            state_nxt      = pblm_pkg::ST_RESULT;
          end else begin
            // Lookup: latch the byte position and request fields, start the walk.
            pos_nxt    = pblm_pkg::POS_W'(in_block_number) << pblm_pkg::BLOCK_SHIFT;
            scnt_nxt   = bytes_up[pblm_pkg::SECTOR_SHIFT +: pblm_pkg::SCNT_W];
            cmd_wr_nxt = in_is_write;
            end_nxt    = '0;
            rd_cnt_nxt = '0;
            state_nxt  = pblm_pkg::ST_WALK;
          end
        end
      end

      pblm_pkg::ST_WALK: begin
        // Issue one slot read per cycle.
        if (int'(rd_cnt_r) < pblm_pkg::NSLOTS) begin
          rd_en      = 1'b1;
          dv_nxt     = 1'b1;
          dq_nxt     = rd_cnt_r[pblm_pkg::SLOT_W-1:0];
          rd_cnt_nxt = rd_cnt_r + pblm_pkg::CNT_W'(1);
        end
        // Extend the running region end by the slot just read; an empty slot adds nothing
        // and cannot match because the position already lies at or past the old end.
        if (dv_r) begin
          end_nxt = new_end;
          if (pblm_pkg::END_W'(pos_r) < new_end) begin
            hit_slot_nxt = dq_r;
            hit_base_nxt = tbl_rd.base;
            end_nxt      = end_r;
            state_nxt    = pblm_pkg::ST_OFFSET;
          end else if (int'(dq_r) == pblm_pkg::NSLOTS - 1) begin
            res_status_nxt = pblm_pkg::STATUS_NOT_FOUND;
            res_dev_nxt    = '0;
            res_off_nxt    = '0;
            res_lba_nxt    = '0;
            res_scnt_nxt   = '0;
            res_cmd_nxt    = 1'b0;
            state_nxt      = pblm_pkg::ST_RESULT;
          end
        end
      end

      pblm_pkg::ST_OFFSET: begin
        // Offset inside the matched partition and its device number.
        res_status_nxt = pblm_pkg::STATUS_OK;
        res_off_nxt    = diff[pblm_pkg::OFF_W-1:0];
        if (hit_slot_r == '0) begin
          res_dev_nxt = pblm_pkg::DEV_W'(pblm_pkg::PRIMARY_DEVICE);
        end else begin
          res_dev_nxt = dev_full[pblm_pkg::DEV_W-1:0];
        end
        res_scnt_nxt = scnt_r;
        res_cmd_nxt  = cmd_wr_r;
        state_nxt    = pblm_pkg::ST_LBA;
      end

      pblm_pkg::ST_LBA: begin
        // Absolute sector is the partition base plus the offset in sectors.
        res_lba_nxt = lba_sum[pblm_pkg::LBA_W-1:0];
        state_nxt   = pblm_pkg::ST_RESULT;
      end

      pblm_pkg::ST_RESULT: begin
        // Hand the result over once the output register is free.
        if (!out_valid_r || !out_stall) begin
          out_load  = 1'b1;
          state_nxt = pblm_pkg::ST_IDLE;
        end
      end

      default: begin
        state_nxt = pblm_pkg::ST_IDLE;
      end
    endcase
  end

  // Output valid tracks loads and completed transactions.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= pblm_pkg::ST_IDLE;
      dv_r        <= 1'b0;
      rd_cnt_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      dv_r        <= dv_nxt;
      rd_cnt_r    <= rd_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    dq_r         <= dq_nxt;
    pos_r        <= pos_nxt;
    end_r        <= end_nxt;
    hit_slot_r   <= hit_slot_nxt;
    hit_base_r   <= hit_base_nxt;
    scnt_r       <= scnt_nxt;
    cmd_wr_r     <= cmd_wr_nxt;
    res_status_r <= res_status_nxt;
    res_dev_r    <= res_dev_nxt;
    res_off_r    <= res_off_nxt;
    res_lba_r    <= res_lba_nxt;
    res_scnt_r   <= res_scnt_nxt;
    res_cmd_r    <= res_cmd_nxt;
  end

  // Output payload register.
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_status_r <= res_status_r;
      out_dev_r    <= res_dev_r;
      out_off_r    <= res_off_r;
      out_lba_r    <= res_lba_r;
      out_scnt_r   <= res_scnt_r;
      out_cmd_r    <= res_cmd_r;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_status           = out_status_r;
  assign out_device_number    = out_dev_r;
  assign out_offset_bytes     = out_off_r;
  assign out_lba              = out_lba_r;
  assign out_sector_count     = out_scnt_r;
  assign out_command_is_write = out_cmd_r;

endmodule

// ===== bench/testbench.sv =====
// Self-checking testbench for the partition block-to-LBA mapper.
`timescale 1ns / 1ps

module testbench;

  // One input transaction, field by field.
  typedef struct packed {
    logic [pblm_pkg::FUNC_W-1:0]  func;
    logic [pblm_pkg::IDX_W-1:0]   slot_index;
    logic [pblm_pkg::DATA_W-1:0]  slot_base;
    logic [pblm_pkg::DATA_W-1:0]  slot_size;
    logic [pblm_pkg::BLOCK_W-1:0] block_number;
    logic [pblm_pkg::BYTES_W-1:0] byte_count;
    logic                         is_write;
  } map_request_t;

  // One result transaction, in the same field order as the output ports.
  typedef struct packed {
    logic                        status;
    logic [pblm_pkg::DEV_W-1:0]  device_number;
    logic [pblm_pkg::OFF_W-1:0]  offset_bytes;
    logic [pblm_pkg::LBA_W-1:0]  lba;
    logic [pblm_pkg::SCNT_W-1:0] sector_count;
    logic                        command_is_write;
  } mapping_t;

  logic                          clk;
  logic                          rst_n = 1'b0;
  logic                          in_valid = 1'b0;
  logic                          in_stall;
  logic [pblm_pkg::FUNC_W-1:0]   in_func = '0;
  logic [pblm_pkg::IDX_W-1:0]    in_slot_index = '0;
  logic [pblm_pkg::DATA_W-1:0]   in_slot_base = '0;
  logic [pblm_pkg::DATA_W-1:0]   in_slot_size = '0;
  logic [pblm_pkg::BLOCK_W-1:0]  in_block_number = '0;
  logic [pblm_pkg::BYTES_W-1:0]  in_byte_count = '0;
  logic                          in_is_write = 1'b0;
  logic                          out_valid;
  logic                          out_stall = 1'b0;
  logic                          out_status;
  logic [pblm_pkg::DEV_W-1:0]    out_device_number;
  logic [pblm_pkg::OFF_W-1:0]    out_offset_bytes;
  logic [pblm_pkg::LBA_W-1:0]    out_lba;
  logic [pblm_pkg::SCNT_W-1:0]   out_sector_count;
  logic                          out_command_is_write;

  // Shadow copy of the partition table, cleared like the block at reset.
  logic [pblm_pkg::DATA_W-1:0] slot_base_copy [pblm_pkg::NSLOTS] = '{default: '0};
  logic [pblm_pkg::DATA_W-1:0] slot_size_copy [pblm_pkg::NSLOTS] = '{default: '0};

  mapping_t pending_mappings [$];
  int       error_count = 0;
  int       in_idle_pct = 33;
  int       out_stall_pct = 33;
  int       hold_cycles_left = 0;

  partition_block_to_lba_mapper i_dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_func              (in_func),
    .in_slot_index        (in_slot_index),
    .in_slot_base         (in_slot_base),
    .in_slot_size         (in_slot_size),
    .in_block_number      (in_block_number),
    .in_byte_count        (in_byte_count),
    .in_is_write          (in_is_write),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_status           (out_status),
    .out_device_number    (out_device_number),
    .out_offset_bytes     (out_offset_bytes),
    .out_lba              (out_lba),
    .out_sector_count     (out_sector_count),
    .out_command_is_write (out_command_is_write)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Applies a transaction to the shadow table and returns the result it should produce.
  // A lookup walks the non-empty slots as back-to-back byte regions.
  function automatic mapping_t compute_mapping(input map_request_t req);
    mapping_t    result;
    logic [63:0] position;
    logic [63:0] region_start;
    logic [63:0] region_end;
    logic [63:0] span;
    logic [63:0] offset;
    logic [63:0] sectors;
    result = '0;
    if (req.func == pblm_pkg::FUNC_TABLE_WRITE) begin
      // Writes past the last logical slot leave the table alone.
      if (req.slot_index < pblm_pkg::NSLOTS) begin
        slot_base_copy[req.slot_index] = req.slot_base;
        slot_size_copy[req.slot_index] = req.slot_size;
      end
      return result;
    end
    position = 64'(req.block_number) * pblm_pkg::BLOCK_BYTES;
    region_end = '0;
    for (int slot = 0; slot < pblm_pkg::NSLOTS; slot++) begin
      span = 64'(slot_size_copy[slot]) * pblm_pkg::SECTOR_BYTES;
      if (span != 0) begin
        region_start = region_end;
        region_end = region_end + span;
        if (position < region_end) begin
          offset = position - region_start;
          sectors = (64'(req.byte_count) + pblm_pkg::SECTOR_BYTES - 1) / pblm_pkg::SECTOR_BYTES;
          result.status = pblm_pkg::STATUS_OK;
          result.device_number =
            (slot == 0) ? pblm_pkg::DEV_W'(pblm_pkg::PRIMARY_DEVICE)
                        : pblm_pkg::DEV_W'(pblm_pkg::FIRST_LOGICAL_MINOR + slot - 1);
          result.offset_bytes = offset[pblm_pkg::OFF_W-1:0];
          result.lba = pblm_pkg::LBA_W'(64'(slot_base_copy[slot]) +
                                        offset / pblm_pkg::SECTOR_BYTES);
          result.sector_count = sectors[pblm_pkg::SCNT_W-1:0];
          result.command_is_write = req.is_write;
          return result;
        end
      end
    end
    result.status = pblm_pkg::STATUS_NOT_FOUND;
    return result;
  endfunction

  // Mostly small partitions so that lookups reach deep slots, with some empty and some huge.
  function automatic logic [pblm_pkg::DATA_W-1:0] random_slot_size();
    int pick;
    pick = $urandom_range(99);
    if (pick < 20) return '0;
    if (pick < 95) return pblm_pkg::DATA_W'($urandom_range(1, 4096));
    return pblm_pkg::DATA_W'($urandom);
  endfunction

  // Picks a block mostly inside the covered area, now and then past its end or anywhere.
  function automatic logic [pblm_pkg::BLOCK_W-1:0] random_block_number();
    logic [63:0] sectors;
    logic [63:0] reach;
    sectors = '0;
    foreach (slot_size_copy[s]) sectors += 64'(slot_size_copy[s]);
    reach = sectors * pblm_pkg::SECTOR_BYTES / pblm_pkg::BLOCK_BYTES;
    reach = reach + reach / 8 + 1;
    if (reach > 64'h7FFF_FFFF || $urandom_range(9) == 0) return pblm_pkg::BLOCK_W'($urandom);
    return pblm_pkg::BLOCK_W'($urandom_range(0, 32'(reach)));
  endfunction

  // Sends one transaction after a random idle gap and records its expected result.
  task automatic issue_request(input map_request_t req);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_func         <= req.func;
    in_slot_index   <= req.slot_index;
    in_slot_base    <= req.slot_base;
    in_slot_size    <= req.slot_size;
    in_block_number <= req.block_number;
    in_byte_count   <= req.byte_count;
    in_is_write     <= req.is_write;
    in_valid        <= 1'b1;
    do @(posedge clk); while (in_stall);
    pending_mappings.push_back(compute_mapping(req));
  endtask

  // Table write; the lookup fields carry random values the block must ignore.
  task automatic write_slot(input logic [pblm_pkg::IDX_W-1:0] index,
                            input logic [pblm_pkg::DATA_W-1:0] base,
                            input logic [pblm_pkg::DATA_W-1:0] size);
    map_request_t req;
    req.func         = pblm_pkg::FUNC_TABLE_WRITE;
    req.slot_index   = index;
    req.slot_base    = base;
    req.slot_size    = size;
    req.block_number = pblm_pkg::BLOCK_W'($urandom);
    req.byte_count   = pblm_pkg::BYTES_W'($urandom);
    req.is_write     = 1'($urandom);
    issue_request(req);
  endtask

  // Lookup; the table-write fields carry random values the block must ignore.
  task automatic lookup_block(input logic [pblm_pkg::BLOCK_W-1:0] block,
                              input logic [pblm_pkg::BYTES_W-1:0] bytes,
                              input logic is_write);
    map_request_t req;
    req.func         = pblm_pkg::FUNC_LOOKUP;
    req.slot_index   = pblm_pkg::IDX_W'($urandom);
    req.slot_base    = pblm_pkg::DATA_W'($urandom);
    req.slot_size    = pblm_pkg::DATA_W'($urandom);
    req.block_number = block;
    req.byte_count   = bytes;
    req.is_write     = is_write;
    issue_request(req);
  endtask

  // Stops offering transactions until every expected result has come back.
  task automatic wait_all_mapped();
    in_valid <= 1'b0;
    while (pending_mappings.size() != 0) @(posedge clk);
  endtask

  // Lookups against the cleared table find nothing.
  task automatic test_empty_table();
    lookup_block('0, pblm_pkg::BYTES_W'(512), 1'b0);
    lookup_block('1, '1, 1'b1);
  endtask

  // Sparse table: primary, an empty slot, a base near wrap, a huge last slot, and two out-of-range writes.
  task automatic test_slot_writes();
    write_slot(pblm_pkg::IDX_W'(0), pblm_pkg::DATA_W'(100), pblm_pkg::DATA_W'(4));
    write_slot(pblm_pkg::IDX_W'(1), '0, '0);
    write_slot(pblm_pkg::IDX_W'(2), 32'hFFFF_FFF0, pblm_pkg::DATA_W'(8));
    write_slot(pblm_pkg::IDX_W'(pblm_pkg::NSLOTS - 1), '1, '1);
    write_slot(pblm_pkg::IDX_W'(pblm_pkg::NSLOTS), '1, pblm_pkg::DATA_W'(1));
    write_slot('1, '1, '1);
  endtask

  // Lookups across the sparse table, covering sector rounding, LBA wrap and empty slots.
  task automatic test_directed_lookups();
    lookup_block('0, '0, 1'b0);
    lookup_block(pblm_pkg::BLOCK_W'(1), pblm_pkg::BYTES_W'(1), 1'b1);
    lookup_block(pblm_pkg::BLOCK_W'(2), pblm_pkg::BYTES_W'(512), 1'b0);
    lookup_block(pblm_pkg::BLOCK_W'(5), pblm_pkg::BYTES_W'(513), 1'b1);
    lookup_block(pblm_pkg::BLOCK_W'(6), pblm_pkg::BYTES_W'(20'h20000), 1'b0);
    lookup_block('1, '1, 1'b1);
    // Emptying the last slot leaves the far end uncovered.
    write_slot(pblm_pkg::IDX_W'(pblm_pkg::NSLOTS - 1), '0, '0);
    lookup_block(pblm_pkg::BLOCK_W'(6), pblm_pkg::BYTES_W'(1024), 1'b0);
    // Emptying the primary moves block zero into the first logical region in use.
    write_slot(pblm_pkg::IDX_W'(0), '0, '0);
    lookup_block('0, pblm_pkg::BYTES_W'(511), 1'b1);
    wait_all_mapped();
  endtask

  // Long receiver hold while the sender keeps going, so the block backs up to its input.
  task automatic test_output_backpressure();
    for (int slot = 0; slot < pblm_pkg::NSLOTS; slot++) begin
      write_slot(pblm_pkg::IDX_W'(slot), $urandom, pblm_pkg::DATA_W'(64));
    end
    wait_all_mapped();
    hold_cycles_left = 300;
    in_idle_pct = 0;
    for (int n = 0; n < 12; n++) begin
      lookup_block(random_block_number(), pblm_pkg::BYTES_W'($urandom), 1'b1);
    end
    wait_all_mapped();
    in_idle_pct = 33;
  endtask

  // Fills the table with random slots, then mixes lookups with table updates.
  task automatic test_random_traffic(input int item_count);
    logic [pblm_pkg::IDX_W-1:0] index;
    for (int slot = 0; slot < pblm_pkg::NSLOTS; slot++) begin
      write_slot(pblm_pkg::IDX_W'(slot), $urandom, random_slot_size());
    end
    for (int n = pblm_pkg::NSLOTS; n < item_count; n++) begin
      // A stretch with no idling on either side.
      if (n == item_count / 2) begin
        in_idle_pct = 0;
        out_stall_pct = 0;
      end
      if (n == item_count / 2 + 80) begin
        in_idle_pct = 33;
        out_stall_pct = 33;
      end
      if ($urandom_range(99) < 15) begin
        index = ($urandom_range(9) == 0)
                  ? pblm_pkg::IDX_W'($urandom_range(pblm_pkg::NSLOTS, 2 ** pblm_pkg::IDX_W - 1))
                  : pblm_pkg::IDX_W'($urandom_range(0, pblm_pkg::NSLOTS - 1));
        write_slot(index, $urandom, random_slot_size());
      end else begin
        lookup_block(random_block_number(), pblm_pkg::BYTES_W'($urandom), 1'($urandom));
      end
    end
  endtask

  // Receiver: random stalls, or a counted hold when a test asks for one.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_cycles_left > 0) begin
        out_stall <= 1'b1;
        hold_cycles_left--;
      end else begin
        out_stall <= ($urandom_range(99) < out_stall_pct);
      end
    end
  end

  // Compares every accepted result transaction with the oldest expectation.
  always @(posedge clk) begin : check_results
    mapping_t want;
    mapping_t got;
    if (rst_n && out_valid && !out_stall) begin
      got = {out_status, out_device_number, out_offset_bytes, out_lba, out_sector_count,
             out_command_is_write};
      if (pending_mappings.size() == 0) begin
        error_count++;
        if (error_count <= 10) $display("%0t: unexpected result %p", $realtime, got);
      end else begin
        want = pending_mappings.pop_front();
        if (got !== want) begin
          error_count++;
          if (error_count <= 10) begin
            $display("%0t: mismatch expected status=%0d dev=%0d off=%0h lba=%0h cnt=%0d wr=%0d",
                     $realtime, want.status, want.device_number, want.offset_bytes, want.lba,
                     want.sector_count, want.command_is_write);
            $display("%0t:          actual   status=%0d dev=%0d off=%0h lba=%0h cnt=%0d wr=%0d",
                     $realtime, got.status, got.device_number, got.offset_bytes, got.lba,
                     got.sector_count, got.command_is_write);
          end
        end
      end
    end
  end

  // Test sequence.
  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    test_empty_table();
    test_slot_writes();
    test_directed_lookups();
    test_output_backpressure();
    test_random_traffic(320);
    wait_all_mapped();
    repeat (80) @(posedge clk);
    if (error_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Run limit, far beyond the slowest correct run.
  initial begin
    #(10_000_000);
    $display("FAIL");
    $finish;
  end

endmodule
